// ===== hdl/dbs_pkg.sv =====
`default_nettype none

package dbs_pkg;

  // Field widths on the stream ports
  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W     = 40;
  localparam int S_TDATA_PAD_W = S_TDATA_W - DATA_W - POS_W;
  localparam int M_TDATA_W     = 48;
  localparam int M_TDATA_PAD_W = M_TDATA_W - DATA_W - POS_W - COUNT_W;

  // Widest stored word; values are extended to this before output
  localparam int EXT_W = 64;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_FIND       = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input transaction and the match vector
    logic execute;  // update state and load the result register
  } dbs_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/dbs_ctrl.sv =====
`default_nettype none

module dbs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output dbs_pkg::dbs_cmd_t      cmd_o
);
  import dbs_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign s_tready_o    = (state_q == S_IDLE);
  assign m_tvalid_o    = out_valid_q;
  assign cmd_o.capture = s_tvalid_i && (state_q == S_IDLE);
  // result register is free when empty or being drained this cycle
  assign cmd_o.execute = (state_q == S_EXEC) && (!out_valid_q || m_tready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_tready_i;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.execute) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> !(out_valid_q && !m_tready_i))
    else $error("result overwritten while pending");

  a_exec_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_q)
    else $error("no result after execute");

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_EXEC) && !s_tready_o)
    else $error("capture did not start execution");

endmodule

`default_nettype wire

// ===== hdl/dbs_datapath.sv =====
`default_nettype none

module dbs_datapath #(
  parameter int DEPTH       = dbs_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = dbs_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dbs_pkg::dbs_cmd_t                 cmd_i,
  input  wire logic [dbs_pkg::OPCODE_W-1:0]      opcode_i,
  input  wire logic signed [dbs_pkg::DATA_W-1:0] data_value_i,
  input  wire logic [dbs_pkg::POS_W-1:0]         position_i,
  output logic [dbs_pkg::M_TDATA_W-1:0]          m_tdata_o,
  output logic [dbs_pkg::STATUS_W-1:0]           m_tuser_o
);
  import dbs_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int SW   = IW + 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [IW-1:0] ONE_I     = IW'(1);
  localparam logic [CW-1:0] ONE_C     = CW'(1);
  localparam logic [CW-1:0] FULL_C    = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

  // (base + off) mod DEPTH, base below DEPTH and off at most DEPTH
  function automatic logic [IW-1:0] wrap_slot(input logic [IW-1:0] base,
                                              input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + off;
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[IW-1:0];
  endfunction

  logic [VALUE_WIDTH-1:0] store_q [DEPTH];
  logic [IW-1:0]          head_q, head_d;
  logic [CW-1:0]          occ_q, occ_d;

  logic [OPCODE_W-1:0]    op_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [POS_W-1:0]       pos_q;
  logic [DEPTH-1:0]       match_q, match_d;

  logic [M_TDATA_W-1:0]   m_tdata_q;
  logic [STATUS_W-1:0]    m_tuser_q;

  logic [EXT_W-1:0]       val_wide;
  logic [VALUE_WIDTH-1:0] val_in;

  logic [IW-1:0]          head_dec, head_inc, back_slot, rd_slot;
  logic                   full, empty;
  logic [POS_W-1:0]       pos_eff;
  logic                   read_ok;
  logic [SW-1:0]          rd_off;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [EXT_W-1:0]       rd_ext;

  logic [2*DEPTH-1:0]     match_dbl;
  logic [DEPTH-1:0]       rot, hit;
  logic [IW-1:0]          pick;
  logic                   found;

  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [DATA_W-1:0]      vout;
  logic [POS_W-1:0]       pout;
  status_e                st;

  // stored words keep the low bits of the zero-extended 32-bit field
  assign val_wide = EXT_W'($unsigned(data_value_i));
  assign val_in   = val_wide[VALUE_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (store_q[i] == val_in);
    end
  end

  assign full      = (occ_q == FULL_C);
  assign empty     = (occ_q == '0);
  assign head_dec  = (head_q == '0) ? LAST_SLOT : head_q - ONE_I;
  assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + ONE_I;
  assign back_slot = wrap_slot(head_q, SW'(occ_q));

  assign pos_eff = (pos_q == '0) ? POS_W'(1) : pos_q;
  assign read_ok = (CMPW'(pos_eff) <= CMPW'(occ_q));
  assign rd_off  = read_ok ? SW'(pos_eff - POS_W'(1)) : '0;
  assign rd_slot = wrap_slot(head_q, rd_off);
  assign rd_val  = store_q[rd_slot];
  assign rd_ext  = EXT_W'($signed(rd_val));

  // rotate physical match bits into front-relative order, keep live entries
  assign match_dbl = {match_q, match_q};
  assign rot       = DEPTH'(match_dbl >> head_q);

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      hit[k] = rot[k] && (CW'(k) < occ_q);
    end
  end

  always_comb begin
    pick = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (hit[k]) pick = IW'(k);
    end
  end

  assign found = |hit;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head_q;
    head_d  = head_q;
    occ_d   = occ_q;
    vout    = '0;
    pout    = '0;
    st      = STAT_OK;
    case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          st = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head_dec;
          head_d  = head_dec;
          occ_d   = occ_q + ONE_C;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = back_slot;
          occ_d   = occ_q + ONE_C;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = STAT_EMPTY;
        end else begin
          head_d = head_inc;
          occ_d  = occ_q - ONE_C;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st = STAT_EMPTY;
        end else begin
          occ_d = occ_q - ONE_C;
        end
      end
      OP_READ: begin
        if (read_ok) begin
          vout = rd_ext[DATA_W-1:0];
        end else begin
          st = STAT_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (found) begin
          pout = POS_W'(SW'(pick) + SW'(1));
        end else begin
          st = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
    end else if (cmd_i.execute) begin
      head_q <= head_d;
      occ_q  <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      val_q   <= val_in;
      pos_q   <= position_i;
      match_q <= match_d;
    end
    if (cmd_i.execute) begin
      m_tdata_q <= {{M_TDATA_PAD_W{1'b0}}, COUNT_W'(occ_d), pout, vout};
      m_tuser_q <= st;
    end
    if (cmd_i.execute && wr_en) begin
      store_q[wr_addr] <= val_q;
    end
  end

  assign m_tdata_o = m_tdata_q;
  assign m_tuser_o = m_tuser_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FULL_C)
    else $error("occupancy above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && (op_q == OP_PUSH_BACK || op_q == OP_PUSH_FRONT) && !full)
      |=> occ_q == $past(occ_q) + ONE_C)
    else $error("push did not grow occupancy");

  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && op_q == OP_READ)
      |=> ((m_tuser_q == STAT_NOT_FOUND) == $past(!read_ok)))
    else $error("read status mismatch");

endmodule

`default_nettype wire

// ===== hdl/bounded_deque_with_search_unit.sv =====
// Bounded double-ended queue of signed words with read-by-position and find.
// Input stream (s_axis): tuser carries the opcode (push front/back, pop
// front/back, read at position, find value); tdata carries the value and the
// 1-based position. Output stream (m_axis): one result per input
// transaction, with the read value, the found position, the entry count
// after the operation in tdata and the status code in tuser.
// No new input transaction is taken until the previous one has executed.
// The capture step compares the search value against all DEPTH entries in
// parallel and registers the match vector; the execute step rotates it to
// front order, picks the first live match, updates head/count and the store,
// and loads the result register.
// A stalled receiver holds the result register; the next input transaction
// is still taken and waits in the execute step until the register frees up.
// Reset empties the queue at once (head and count cleared); store contents
// are not cleared, and entries are only ever read after they were pushed.
`default_nettype none

module bounded_deque_with_search_unit #(
  parameter int DEPTH       = dbs_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = dbs_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] data_value, [36:32] position, [39:37] zero
  input  wire logic [dbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] opcode
  input  wire logic [dbs_pkg::OPCODE_W-1:0]    s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] value_out, [36:32] position_out, [41:37] entry_count, [47:42] zero
  output logic [dbs_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // [1:0] status
  output logic [dbs_pkg::STATUS_W-1:0]         m_axis_tuser
);
  import dbs_pkg::*;

  dbs_cmd_t                 cmd;
  logic signed [DATA_W-1:0] data_value;
  logic [POS_W-1:0]         position;

  assign data_value = s_axis_tdata[DATA_W-1:0];
  assign position   = s_axis_tdata[DATA_W+POS_W-1:DATA_W];

  dbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  dbs_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (s_axis_tuser),
    .data_value_i (data_value),
    .position_i   (position),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire
